### rtl/core/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types and constants for the counting semaphore with waiter queue.
// ----------------------------------------------------------------------------
package csfw_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam int KIND_W   = 2;
    localparam int REQ_W    = 8;
    localparam int EV_W     = 4;
    localparam int COUNT_W  = 16;
    localparam int WAIT_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);

    typedef logic [ID_BITS-1:0] t_id;
    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [FILL_W-1:0]  t_fill;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CANCEL  = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [EV_W-1:0] {
        EV_GRANTED      = 4'd0,
        EV_QUEUED       = 4'd1,
        EV_REFUSED      = 4'd2,
        EV_RETURNED     = 4'd3,
        EV_IGNORED      = 4'd4,
        EV_HANDED       = 4'd5,
        EV_REJECTED     = 4'd6,
        EV_CANCEL_EMPTY = 4'd7,
        EV_OVERFLOW     = 4'd8
    } t_event;

    typedef struct packed {
        t_kind kind;
        t_id   id;
    } t_cmd;

    typedef struct packed {
        t_event               ev;
        logic [REQ_W-1:0]     grantee;
        logic [COUNT_W-1:0]   free_tokens;
        logic [WAIT_W-1:0]    waiting;
        logic                 last;
    } t_result;

    typedef struct packed {
        t_fill fill;
        logic  cancelled;
        logic  flushing;
    } t_back_status;

endpackage

### rtl/core/counting_semaphore_fifo_waiters_core.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_core
// Counting semaphore with a FIFO of waiting requesters and a sticky cancel.
// ----------------------------------------------------------------------------
// Input channel: drive kind/requester_id with push; a beat is taken when push
// is high and full is low. Kind 0 acquires, 1 releases, 2 cancels.
// Result channel: while empty is low the oldest result sits on the o_ ports;
// pop takes it. Each result carries the event, the id concerned, the free
// count and the number of waiters after the event, and last on the final one.
// Acquire and release put one result on the result ports via the registered
// command and result queues; they sustain one beat per cycle while results
// are popped. A cancel with N waiters gives N results, one per cycle from the
// sequencer while the result queue has room, or one result with no waiters.
// A stalled result port fills the two-entry result queue, then holds the
// sequencer, then fills the two-entry command queue, and then raises full.
// Config: a beat on the cfg channel loads the free count; o_cfg_ready is
// always high. Write it only while no result is outstanding.
// Reset (synchronous, active low) sets the free count to one, empties both
// queues and the waiter list and clears the cancelled flag.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_requester_id,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_event_res,
    output logic [7:0]  o_grantee_id,
    output logic [15:0] o_free_tokens,
    output logic [4:0]  o_waiting,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import csfw_pkg::*;

    logic         w_cmd_valid;
    t_cmd         w_cmd;
    logic         w_cmd_take;
    logic         w_res_valid;
    logic         w_res_ready;
    t_result      w_res;
    t_result      w_out;
    t_back_status w_status;

    assign o_cfg_ready = 1'b1;

    csfw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_kind         (i_kind),
        .i_requester_id (i_requester_id),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_take     (w_cmd_take)
    );

    csfw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_res_ready (w_res_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_status    (w_status)
    );

    csfw_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_res_valid),
        .i_wr_data  (w_res),
        .o_wr_ready (w_res_ready),
        .o_empty    (empty),
        .o_data     (w_out),
        .i_pop      (pop)
    );

    assign o_event_res   = w_out.ev;
    assign o_grantee_id  = w_out.grantee;
    assign o_free_tokens = w_out.free_tokens;
    assign o_waiting     = w_out.waiting;
    assign o_last        = w_out.last;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.fill <= FILL_W'(QUEUE_DEPTH))
        else $error("waiter count above queue depth");

    a_cancel_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.cancelled |=> w_status.cancelled)
        else $error("cancelled flag dropped");

    a_flush_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready && w_res.ev == EV_REJECTED && w_res.last)
        |=> (w_status.fill == '0 && !w_status.flushing))
        else $error("flush ended with waiters left");

    a_no_grant_cancelled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res.ev == EV_GRANTED) |-> !w_status.cancelled)
        else $error("grant after cancel");
`endif

endmodule

### rtl/core/csfw_front.sv
// ----------------------------------------------------------------------------
// csfw_front
// Input side: accepts beats, drops unused kinds, buffers commands for the back.
// ----------------------------------------------------------------------------
module csfw_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [1:0]                i_kind,
    input  logic [7:0]                i_requester_id,
    output logic                      o_cmd_valid,
    output csfw_pkg::t_cmd            o_cmd,
    input  logic                      i_cmd_take
);
    import csfw_pkg::*;

    t_cmd       r_cmd_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    logic w_accept;
    logic w_store;
    t_cmd w_cmd_in;

    assign o_full      = (r_count == 2'd2);
    assign w_accept    = i_push && !o_full;
    // unused kind causes nothing: accepted but never forwarded
    assign w_store     = w_accept && (t_kind'(i_kind) != KIND_UNUSED);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_cmd_q[r_rd_ptr];

    always_comb begin
        w_cmd_in.kind = t_kind'(i_kind);
        w_cmd_in.id   = ID_BITS'(i_requester_id);
        n_count = r_count;
        if (w_store && !(i_cmd_take && o_cmd_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!w_store && i_cmd_take && o_cmd_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_store) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_take && o_cmd_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_cmd_q[r_wr_ptr] <= w_cmd_in;
        end
    end

endmodule

### rtl/core/csfw_back.sv
// ----------------------------------------------------------------------------
// csfw_back
// Execution side: token count, waiter queue, cancel flag and flush sequencer.
// ----------------------------------------------------------------------------
module csfw_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  csfw_pkg::t_cmd            i_cmd,
    output logic                      o_cmd_take,
    input  logic                      i_res_ready,
    output logic                      o_res_valid,
    output csfw_pkg::t_result         o_res,
    input  logic                      i_cfg_valid,
    input  logic [15:0]               i_cfg_data,
    output csfw_pkg::t_back_status    o_status
);
    import csfw_pkg::*;

    typedef enum logic [1:0] {
        BS_RUN   = 2'b01,
        BS_FLUSH = 2'b10
    } t_bstate;

    t_bstate              r_state, n_state;
    logic [COUNT_W-1:0]   r_free, n_free;
    t_id                  r_queue [QUEUE_DEPTH];
    t_ptr                 r_head, n_head;
    t_ptr                 r_tail, n_tail;
    t_fill                r_fill, n_fill;
    logic                 r_cancelled, n_cancelled;

    logic w_q_we;
    t_id  w_head_id;
    t_ptr w_head_inc;
    t_ptr w_tail_inc;

    assign w_head_id  = r_queue[r_head];
    assign w_head_inc = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign w_tail_inc = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);

    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_cancelled = r_cancelled;
        w_q_we      = 1'b0;
        o_cmd_take  = 1'b0;
        o_res_valid = 1'b0;
        o_res.ev      = EV_GRANTED;
        o_res.grantee = '0;
        o_res.last    = 1'b1;

        case (r_state)
            BS_RUN: begin
                if (i_cmd_valid && i_res_ready) begin
                    o_cmd_take  = 1'b1;
                    o_res_valid = 1'b1;
                    case (i_cmd.kind)
                        KIND_ACQUIRE: begin
                            o_res.grantee = REQ_W'(i_cmd.id);
                            if (r_cancelled) begin
                                o_res.ev = EV_REFUSED;
                            end else if (r_free != '0) begin
                                n_free   = r_free - COUNT_W'(1);
                                o_res.ev = EV_GRANTED;
                            end else if (r_fill == FILL_W'(QUEUE_DEPTH)) begin
                                o_res.ev = EV_OVERFLOW;
                            end else begin
                                w_q_we   = 1'b1;
                                n_tail   = w_tail_inc;
                                n_fill   = r_fill + FILL_W'(1);
                                o_res.ev = EV_QUEUED;
                            end
                        end
                        KIND_RELEASE: begin
                            if (r_cancelled) begin
                                o_res.ev = EV_IGNORED;
                            end else if (r_fill != '0) begin
                                n_head        = w_head_inc;
                                n_fill        = r_fill - FILL_W'(1);
                                o_res.ev      = EV_HANDED;
                                o_res.grantee = REQ_W'(w_head_id);
                            end else if (r_free == COUNT_MAX) begin
                                o_res.ev = EV_OVERFLOW;
                            end else begin
                                n_free   = r_free + COUNT_W'(1);
                                o_res.ev = EV_RETURNED;
                            end
                        end
                        KIND_CANCEL: begin
                            n_cancelled = 1'b1;
                            if (r_fill == '0) begin
                                o_res.ev = EV_CANCEL_EMPTY;
                            end else begin
                                // BS_FLUSH rejects one waiter per cycle on i_res_ready
                                o_res_valid = 1'b0;
                                n_state     = BS_FLUSH;
                            end
                        end
                        default: begin
                            o_res_valid = 1'b0;
                        end
                    endcase
                end
            end
            BS_FLUSH: begin
                if (i_res_ready) begin
                    o_res_valid   = 1'b1;
                    o_res.ev      = EV_REJECTED;
                    o_res.grantee = REQ_W'(w_head_id);
                    n_fill        = r_fill - FILL_W'(1);
                    n_head        = w_head_inc;
                    o_res.last    = (n_fill == '0);
                    if (n_fill == '0) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_state = BS_RUN;
                    end
                end
            end
            default: begin
                n_state = BS_RUN;
            end
        endcase

        // config must only be written while idle; the block does not enforce it
        if (i_cfg_valid) begin
            n_free = i_cfg_data;
        end

        o_res.free_tokens = n_free;
        o_res.waiting     = WAIT_W'(n_fill);
    end

    assign o_status.fill      = r_fill;
    assign o_status.cancelled = r_cancelled;
    assign o_status.flushing  = (r_state == BS_FLUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_RUN;
            r_free      <= COUNT_RST;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_cancelled <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_cancelled <= n_cancelled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_queue[r_tail] <= i_cmd.id;
        end
    end

endmodule

### rtl/core/csfw_outq.sv
// ----------------------------------------------------------------------------
// csfw_outq
// Two-entry result queue between the back and the result port.
// ----------------------------------------------------------------------------
module csfw_outq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_valid,
    input  csfw_pkg::t_result         i_wr_data,
    output logic                      o_wr_ready,
    output logic                      o_empty,
    output csfw_pkg::t_result         o_data,
    input  logic                      i_pop
);
    import csfw_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    logic w_wr;
    logic w_rd;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_data     = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### tb/tb_counting_semaphore_fifo_waiters_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_fifo_waiters_core
// Self-checking bench for the counting semaphore core. A predictor keeps its
// own free count, waiter FIFO and cancel flag, and each result beat is checked
// field by field against the oldest predicted result. Directed corner cases
// run first. Random acquire/release traffic follows across several token
// loads. The run ends with a full-queue cancel flush and the cancelled state.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_fifo_waiters_core;
    import csfw_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 50;
    localparam int PHASES        = 7;
    localparam int EXP_DEPTH     = 1024;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        push           = 1'b0;
    logic        full;
    logic [1:0]  i_kind         = KIND_ACQUIRE;
    logic [7:0]  i_requester_id = '0;
    logic        empty;
    logic        pop            = 1'b0;
    logic [3:0]  o_event_res;
    logic [7:0]  o_grantee_id;
    logic [15:0] o_free_tokens;
    logic [4:0]  o_waiting;
    logic        o_last;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data     = '0;

    // predicted semaphore state
    logic [COUNT_W-1:0] sem_free;
    t_id                waiter_ids [QUEUE_DEPTH];
    t_ptr               wq_head;
    t_ptr               wq_tail;
    t_fill              wq_fill;
    logic               sem_cancelled;

    // ring of predicted results, oldest at exp_rd
    t_result            exp_results [EXP_DEPTH];
    int                 exp_wr = 0;
    int                 exp_rd = 0;

    int  items_sent   = 0;
    int  results_seen = 0;
    int  token_loads  = 0;
    int  error_count  = 0;
    int  deepest_wait = 0;
    int  quiet_cycles = 0;
    int  pop_hold     = 0;
    bit  no_idle      = 1'b0;

    counting_semaphore_fifo_waiters_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_requester_id (i_requester_id),
        .empty          (empty),
        .pop            (pop),
        .o_event_res    (o_event_res),
        .o_grantee_id   (o_grantee_id),
        .o_free_tokens  (o_free_tokens),
        .o_waiting      (o_waiting),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_ptr next_ptr(t_ptr p);
        return (p == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic t_result make_result(t_event ev, t_id id, logic fin);
        t_result r;
        r.ev          = ev;
        r.grantee     = REQ_W'(id);
        r.free_tokens = sem_free;
        r.waiting     = WAIT_W'(wq_fill);
        r.last        = fin;
        return r;
    endfunction

    function automatic void add_expected(t_result r);
        exp_results[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    task automatic predict_semaphore(t_kind kind, t_id id);
        t_id w;
        case (kind)
            KIND_ACQUIRE: begin
                if (sem_cancelled) begin
                    add_expected(make_result(EV_REFUSED, id, 1'b1));
                end else if (sem_free != 0) begin
                    sem_free = sem_free - 1'b1;
                    add_expected(make_result(EV_GRANTED, id, 1'b1));
                end else if (wq_fill >= QUEUE_DEPTH) begin
                    add_expected(make_result(EV_OVERFLOW, id, 1'b1));
                end else begin
                    waiter_ids[wq_tail] = id;
                    wq_tail = next_ptr(wq_tail);
                    wq_fill = wq_fill + 1'b1;
                    if (int'(wq_fill) > deepest_wait) deepest_wait = int'(wq_fill);
                    add_expected(make_result(EV_QUEUED, id, 1'b1));
                end
            end
            KIND_RELEASE: begin
                if (sem_cancelled) begin
                    add_expected(make_result(EV_IGNORED, '0, 1'b1));
                end else if (wq_fill != 0) begin
                    w = waiter_ids[wq_head];
                    wq_head = next_ptr(wq_head);
                    wq_fill = wq_fill - 1'b1;
                    add_expected(make_result(EV_HANDED, w, 1'b1));
                end else if (sem_free >= COUNT_MAX) begin
                    add_expected(make_result(EV_OVERFLOW, '0, 1'b1));
                end else begin
                    sem_free = sem_free + 1'b1;
                    add_expected(make_result(EV_RETURNED, '0, 1'b1));
                end
            end
            KIND_CANCEL: begin
                sem_cancelled = 1'b1;
                if (wq_fill == 0) begin
                    add_expected(make_result(EV_CANCEL_EMPTY, '0, 1'b1));
                end else begin
                    // flush oldest first, last flag on the final reject
                    while (wq_fill != 0) begin
                        w = waiter_ids[wq_head];
                        wq_head = next_ptr(wq_head);
                        wq_fill = wq_fill - 1'b1;
                        add_expected(make_result(EV_REJECTED, w, wq_fill == 0));
                    end
                    wq_head = '0;
                    wq_tail = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (error_count < 40)
            $display("[%0t] result %0d: %s got 0x%0h want 0x%0h",
                     $realtime, results_seen, what, got, want);
        error_count++;
    endtask

    // one command beat; returns at the next falling edge with push still high
    task automatic send_op(t_kind kind, t_id id);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        push           <= 1'b1;
        i_kind         <= kind;
        i_requester_id <= id;
        do @(posedge i_clk); while (full);
        predict_semaphore(kind, id);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(negedge i_clk); while (exp_wr != exp_rd);
    endtask

    task automatic load_tokens(logic [COUNT_W-1:0] value);
        drain_results();
        // an unused-kind beat may still be in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sem_free = value;
        token_loads++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_kind pick_kind(int acq_pct, bit with_cancel);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return KIND_UNUSED;
        if (with_cancel && r < 10) return KIND_CANCEL;
        if (r < acq_pct) return KIND_ACQUIRE;
        return KIND_RELEASE;
    endfunction

    task automatic test_basic_ops();
        send_op(KIND_ACQUIRE, 8'h00);   // takes the reset token
        send_op(KIND_ACQUIRE, 8'hFF);
        send_op(KIND_ACQUIRE, 8'hA5);
        send_op(KIND_RELEASE, 8'h12);
        send_op(KIND_UNUSED,  8'h5A);   // no result expected
        send_op(KIND_RELEASE, 8'h00);
        send_op(KIND_RELEASE, 8'hFF);
    endtask

    task automatic test_count_ceiling();
        load_tokens(COUNT_MAX);
        send_op(KIND_RELEASE, 8'h00);   // count pinned at max
        send_op(KIND_ACQUIRE, 8'h3C);
        send_op(KIND_RELEASE, 8'hC3);
    endtask

    task automatic test_full_queue();
        load_tokens('0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_op(KIND_ACQUIRE, t_id'(i * 17));
        send_op(KIND_ACQUIRE, 8'hEE);   // queue full, flagged with the id
        send_op(KIND_RELEASE, 8'h00);
    endtask

    task automatic test_random_traffic();
        logic [COUNT_W-1:0] load;
        int acq_pct;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       load = '0;
                1:       load = COUNT_W'(1);
                2:       load = COUNT_MAX;
                4:       load = COUNT_W'($urandom_range(2, 5));
                default: load = COUNT_W'($urandom_range(0, 65535));
            endcase
            load_tokens(load);
            acq_pct = $urandom_range(35, 65);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2 && phase[0])
                    drain_results();
                send_op(pick_kind(acq_pct, 1'b0), t_id'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_cancel_flush();
        load_tokens('0);
        while (wq_fill < QUEUE_DEPTH)
            send_op(KIND_ACQUIRE, t_id'($urandom_range(0, 255)));
        send_op(KIND_CANCEL,  8'h77);
        send_op(KIND_CANCEL,  8'h00);   // repeated cancel, nobody waiting
        send_op(KIND_ACQUIRE, 8'h81);
        send_op(KIND_RELEASE, 8'h00);
    endtask

    task automatic test_cancelled_tail();
        no_idle = 1'b1;
        load_tokens(COUNT_W'($urandom_range(0, 65535)));
        for (int i = 0; i < 30; i++)
            send_op(pick_kind(50, 1'b1), t_id'($urandom_range(0, 255)));
    endtask

    // result side: pop held low in random stall bursts, none in the cancelled tail
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold = pop_hold - 1;
            pop <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            pop_hold = $urandom_range(0, 8);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (exp_wr == exp_rd) begin
                report_mismatch("result with nothing pending, event", o_event_res, 0);
            end else begin
                want = exp_results[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_event_res !== want.ev)
                    report_mismatch("event_res", o_event_res, want.ev);
                if (o_grantee_id !== want.grantee)
                    report_mismatch("grantee_id", o_grantee_id, want.grantee);
                if (o_free_tokens !== want.free_tokens)
                    report_mismatch("free_tokens", o_free_tokens, want.free_tokens);
                if (o_waiting !== want.waiting)
                    report_mismatch("waiting", o_waiting, want.waiting);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results pending",
                     quiet_cycles, exp_wr - exp_rd);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        sem_free      = COUNT_RST;
        wq_head       = '0;
        wq_tail       = '0;
        wq_fill       = '0;
        sem_cancelled = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_ops();
        test_count_ceiling();
        test_full_queue();
        test_random_traffic();
        test_cancel_flush();
        test_cancelled_tail();

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("covered %0d commands, %0d result beats, %0d token loads, queue depth up to %0d",
                 items_sent, results_seen, token_loads, deepest_wait);
        $display("including count ceiling, full queue overflow, full flush and cancelled state");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
